// ===== hdl/fat16_chain_entry_generator_macros.svh =====
// Assertion helpers shared by the chain entry generator.
// Both sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef FAT16_CHAIN_ENTRY_GENERATOR_MACROS_SVH
`define FAT16_CHAIN_ENTRY_GENERATOR_MACROS_SVH

// Same-cycle implication.
`define FCEG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FCEG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fat16ceg_pkg.sv =====
`default_nettype none

package fat16ceg_pkg;

    // Field widths
    localparam int SLOT_W     = 4;
    localparam int CLUSTER_W  = 16;
    localparam int LEN_W      = 32;
    localparam int ENTRY_W    = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int MAXC_W     = 17;
    localparam int FCNT_W     = 5;
    localparam int CSL_W      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_CLUSTER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILE_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_LOG2 = 2'd2;

    localparam logic [MAXC_W-1:0] MAX_CLUSTER_RST = 17'd65525;

    // Item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // FAT16 entry codes
    localparam logic [ENTRY_W-1:0] ENT_END   = 16'hFFF8;
    localparam logic [ENTRY_W-1:0] ENT_MEDIA = 16'hFFFF;
    localparam logic [ENTRY_W-1:0] ENT_BAD   = 16'hFFF7;
    localparam logic [ENTRY_W-1:0] ENT_FREE  = 16'h0000;

    // Parameter defaults
    localparam int MAX_FILES_DEF   = 16;
    localparam int BLOCK_BYTES_DEF = 512;

    typedef struct packed {
        logic [CLUSTER_W-1:0] start;
        logic [LEN_W-1:0]     len;
    } tbl_entry_t;

    typedef struct packed {
        logic       en;
        tbl_entry_t data;
    } tbl_wr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CUR,
        ST_NEXT,
        ST_END,
        ST_CMP,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/fat16ceg_table.sv =====
`default_nettype none

module fat16ceg_table #(
    parameter int MAX_FILES = fat16ceg_pkg::MAX_FILES_DEF
) (
    input  logic                           clk,
    input  fat16ceg_pkg::tbl_wr_t          wr,
    input  logic [$clog2(MAX_FILES)-1:0]   wr_addr,
    input  logic [$clog2(MAX_FILES)-1:0]   rd_addr,
    output fat16ceg_pkg::tbl_entry_t       rd_data
);
    import fat16ceg_pkg::*;

    tbl_entry_t mem [MAX_FILES];

    // Write on load, read every cycle with a registered output
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hdl/fat16_chain_entry_generator.sv =====
// Load transaction: taken while idle, gives no result; the next transaction may follow at once.
// Query on cluster 0, 1, a bad cluster or an empty table: no table walk, straight to the result.
// Query that walks the table: reads the current entry, restarting at entry 0 if the cluster lies
// before it, steps onto following entries at or below the cluster, then checks the chain end.
// One read port sets the pace; the next item waits until the result enters the output register.
// Reset (rst_n, asynchronous, active low) clears control registers and search index, not the table.
`default_nettype none

module fat16_chain_entry_generator #(
    parameter int MAX_FILES   = fat16ceg_pkg::MAX_FILES_DEF,
    parameter int BLOCK_BYTES = fat16ceg_pkg::BLOCK_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                kind,
    input  logic [fat16ceg_pkg::SLOT_W-1:0]     entry_slot,
    input  logic [fat16ceg_pkg::CLUSTER_W-1:0]  first_cluster,
    input  logic [fat16ceg_pkg::LEN_W-1:0]      byte_length,
    input  logic [fat16ceg_pkg::CLUSTER_W-1:0]  cluster_number,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [fat16ceg_pkg::ENTRY_W-1:0]    fat_entry,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fat16ceg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fat16ceg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fat16ceg_pkg::*;

    `include "fat16_chain_entry_generator_macros.svh"

    // Table index width, count width with headroom for index + 2
    localparam int IW      = $clog2(MAX_FILES);
    localparam int CW      = $clog2(MAX_FILES + 1) + 1;
    localparam int BB_LOG2 = $clog2(BLOCK_BYTES);
    // Width of the end-of-chain cluster: start plus length in blocks, one carry bit
    localparam int EW      = LEN_W - BB_LOG2 + 1;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t               state_reg, state_next;

    logic [MAXC_W-1:0]    max_cluster_reg;
    logic [FCNT_W-1:0]    file_count_reg;
    logic [CSL_W-1:0]     csl_reg;

    logic [IW-1:0]        search_idx_reg, search_idx_next;
    logic                 out_valid_reg, out_valid_next;

    // Payload registers, no reset needed
    logic [IW-1:0]        idx_reg, idx_next;
    logic [CLUSTER_W-1:0] clu_reg, clu_next;
    logic [CLUSTER_W-1:0] cur_start_reg, cur_start_next;
    logic [LEN_W-1:0]     cur_len_reg, cur_len_next;
    logic [EW-1:0]        end_reg, end_next;
    logic [ENTRY_W-1:0]   res_reg, res_next;
    logic [ENTRY_W-1:0]   fat_entry_reg, fat_entry_next;

    // ------------------------------------------------------------------
    // Handshakes and decode
    // ------------------------------------------------------------------
    logic                 acc_query;
    logic                 acc_load;
    logic                 slot_ok;
    logic [CW-1:0]        active_cnt;
    logic [CW-1:0]        idx_plus1;
    logic [CW-1:0]        idx_plus2;
    logic [IW-1:0]        start_idx;
    logic                 is_special;
    logic [ENTRY_W-1:0]   special_res;
    logic                 restart;
    logic                 advance;
    logic                 out_free;

    tbl_wr_t              tbl_wr;
    logic [IW-1:0]        tbl_wr_addr;
    logic [IW-1:0]        rd_addr;
    tbl_entry_t           rd_data;

    // Block takes a transaction only while no query is in flight
    assign in_ready  = (state_reg == ST_IDLE);
    // Configuration must be written only while idle (not enforced here), so it is always taken
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign fat_entry = fat_entry_reg;

    assign acc_query = in_valid && in_ready && (kind == KIND_QUERY);
    assign acc_load  = in_valid && in_ready && (kind == KIND_LOAD);
    assign slot_ok   = (32'(entry_slot) < 32'(MAX_FILES));

    // Usable entries: file count clipped to the table depth
    assign active_cnt = (32'(file_count_reg) < 32'(MAX_FILES)) ?
                        CW'(file_count_reg) : CW'(MAX_FILES);

    assign idx_plus1 = CW'(idx_reg) + CW'(1);
    assign idx_plus2 = CW'(idx_reg) + CW'(2);

    // Drop a stale search index back to the first entry
    assign start_idx = (CW'(search_idx_reg) < active_cnt) ? search_idx_reg : '0;

    // Answers that need no table walk
    always_comb
    begin
        is_special  = 1'b1;
        special_res = ENT_FREE;
        if (cluster_number == '0)
        begin
            special_res = ENT_END;
        end
        else if (cluster_number == CLUSTER_W'(1))
        begin
            special_res = ENT_MEDIA;
        end
        else if (MAXC_W'(cluster_number) >= max_cluster_reg)
        begin
            special_res = ENT_BAD;
        end
        else if (active_cnt == '0)
        begin
            special_res = ENT_FREE;
        end
        else
        begin
            is_special = 1'b0;
        end
    end

    // Cluster lies before the current file: restart the walk at entry 0
    assign restart  = (clu_reg < rd_data.start) && (idx_reg != '0);
    // Following file starts at or below the cluster: step onto it
    assign advance  = (clu_reg >= rd_data.start);
    // Output register can take the next result
    assign out_free = !out_valid_reg || out_ready;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_cluster_reg <= MAX_CLUSTER_RST;
            file_count_reg  <= '0;
            csl_reg         <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MAX_CLUSTER:  max_cluster_reg <= cfg_data[MAXC_W-1:0];
                REG_FILE_COUNT:   file_count_reg  <= cfg_data[FCNT_W-1:0];
                REG_CLUSTER_LOG2: csl_reg         <= cfg_data[CSL_W-1:0];
                default:          ; // unknown index: ignore the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // File table
    // ------------------------------------------------------------------
    always_comb
    begin
        tbl_wr.en         = acc_load && slot_ok;
        tbl_wr.data.start = first_cluster;
        tbl_wr.data.len   = byte_length;
        tbl_wr_addr       = IW'(entry_slot);
    end

    fat16ceg_table #(
        .MAX_FILES (MAX_FILES)
    ) u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .wr_addr (tbl_wr_addr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc_query)
                begin
                    state_next = is_special ? ST_DONE : ST_CUR;
                end
            end
            ST_CUR:
            begin
                if (restart)
                begin
                    state_next = ST_CUR;
                end
                else if (idx_plus1 < active_cnt)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    state_next = ST_END;
                end
            end
            ST_NEXT:
            begin
                if (advance && (idx_plus2 < active_cnt))
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    state_next = ST_END;
                end
            end
            ST_END:  state_next = ST_CMP;
            ST_CMP:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath controls
    // ------------------------------------------------------------------
    always_comb
    begin
        idx_next        = idx_reg;
        clu_next        = clu_reg;
        cur_start_next  = cur_start_reg;
        cur_len_next    = cur_len_reg;
        end_next        = end_reg;
        res_next        = res_reg;
        search_idx_next = search_idx_reg;
        fat_entry_next  = fat_entry_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        rd_addr         = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc_query)
                begin
                    clu_next = cluster_number;
                    res_next = special_res;
                    idx_next = start_idx;
                    rd_addr  = start_idx;
                end
            end
            ST_CUR:
            begin
                if (restart)
                begin
                    idx_next = '0;
                    rd_addr  = '0;
                end
                else
                begin
                    cur_start_next = rd_data.start;
                    cur_len_next   = rd_data.len;
                    if (idx_plus1 < active_cnt)
                    begin
                        rd_addr = IW'(idx_plus1);
                    end
                end
            end
            ST_NEXT:
            begin
                if (advance)
                begin
                    idx_next       = IW'(idx_plus1);
                    cur_start_next = rd_data.start;
                    cur_len_next   = rd_data.len;
                    if (idx_plus2 < active_cnt)
                    begin
                        rd_addr = IW'(idx_plus2);
                    end
                end
            end
            ST_END:
            begin
                // Chain ends at start plus the file length in clusters
                end_next = EW'(cur_start_reg) + EW'((cur_len_reg >> BB_LOG2) >> csl_reg);
            end
            ST_CMP:
            begin
                search_idx_next = idx_reg;
                if (EW'(clu_reg) == end_reg)
                begin
                    res_next = ENT_END;
                end
                else if (EW'(clu_reg) < end_reg)
                begin
                    res_next = clu_reg + CLUSTER_W'(1);
                end
                else
                begin
                    res_next = ENT_FREE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    fat_entry_next = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Register update
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            search_idx_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            search_idx_reg <= search_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        clu_reg       <= clu_next;
        cur_start_reg <= cur_start_next;
        cur_len_reg   <= cur_len_next;
        end_reg       <= end_next;
        res_reg       <= res_next;
        fat_entry_reg <= fat_entry_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // An accepted query must hold off the input on the following cycle
    `FCEG_ASSERT_NEXT(a_query_blocks, acc_query, !in_ready, "query did not block input")
    // A finished result moves into a free output register
    `FCEG_ASSERT_NEXT(a_done_emits, (state_reg == ST_DONE) && out_free, out_valid, "result lost")
    // The table walk never runs on an empty table
    `FCEG_ASSERT_NOW(a_walk_nonempty, state_reg == ST_CUR, active_cnt != '0, "walk on empty table")

endmodule

`default_nettype wire

// ===== bench/fat16_chain_entry_generator_tb.sv =====
`timescale 1ns / 100ps

module fat16_chain_entry_generator_tb;

    import fat16ceg_pkg::*;

    localparam int TBL_DEPTH    = MAX_FILES_DEF;
    localparam int BLOCK_SHIFT  = $clog2(BLOCK_BYTES_DEF);
    localparam int PHASE_ITEMS  = 72;
    localparam int SETTLE_TICKS = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_MAX   = 10;

    // Index 3 is not mapped to any register; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct {
        logic                 kind;
        logic [SLOT_W-1:0]    slot;
        logic [CLUSTER_W-1:0] start;
        logic [LEN_W-1:0]     len;
        logic [CLUSTER_W-1:0] cluster;
    } disk_req_t;

    typedef struct {
        logic [CLUSTER_W-1:0] cluster;
        logic [ENTRY_W-1:0]   entry;
    } fat_answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  kind = KIND_LOAD;
    logic [SLOT_W-1:0]     entry_slot = '0;
    logic [CLUSTER_W-1:0]  first_cluster = '0;
    logic [LEN_W-1:0]      byte_length = '0;
    logic [CLUSTER_W-1:0]  cluster_number = '0;

    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [ENTRY_W-1:0]    fat_entry;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Stimulus queue filled by the sequencer, drained by the driver.
    disk_req_t   disk_requests[$];
    // FAT entries predicted for accepted queries, oldest first.
    fat_answer_t due_entries[$];

    // Shadow copy of the generator: file table, search index and registers.
    logic [CLUSTER_W-1:0] tbl_start[TBL_DEPTH];
    logic [LEN_W-1:0]     tbl_len[TBL_DEPTH];
    int unsigned          walk_idx = 0;
    logic [MAXC_W-1:0]    max_cluster_r = MAX_CLUSTER_RST;
    logic [FCNT_W-1:0]    file_count_r = '0;
    logic [CSL_W-1:0]     cluster_log2_r = '0;

    // File layout of the current phase, used to shape chain walks.
    int unsigned lay_start[TBL_DEPTH];
    int unsigned lay_span[TBL_DEPTH];
    int unsigned lay_lo = 2;
    int unsigned lay_hi = 2;

    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        req_taken = 1'b0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    fat16_chain_entry_generator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .entry_slot     (entry_slot),
        .first_cluster  (first_cluster),
        .byte_length    (byte_length),
        .cluster_number (cluster_number),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .fat_entry      (fat_entry),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Compute the FAT16 entry for cluster c and advance the search index the
    // way the generator does: restart at entry 0 when the index is stale or
    // the cluster lies before the current file, then walk forward.
    function automatic logic [ENTRY_W-1:0] fat_lookup(input logic [CLUSTER_W-1:0] c);
        int unsigned n;
        logic [31:0] chain_end;
        logic [31:0] c_wide;
        n = (file_count_r < TBL_DEPTH) ? file_count_r : TBL_DEPTH;
        c_wide = {16'd0, c};
        if (c == 16'd0)
            return ENT_END;
        if (c == 16'd1)
            return ENT_MEDIA;
        if ({1'b0, c} >= max_cluster_r)
            return ENT_BAD;
        if (n == 0)
            return ENT_FREE;
        if (walk_idx >= n || c < tbl_start[walk_idx])
            walk_idx = 0;
        while (walk_idx + 1 < n && c >= tbl_start[walk_idx + 1])
            walk_idx++;
        chain_end = {16'd0, tbl_start[walk_idx]} +
                    ((tbl_len[walk_idx] >> BLOCK_SHIFT) >> cluster_log2_r);
        if (c_wide == chain_end)
            return ENT_END;
        if (c_wide < chain_end)
            return c + 16'd1;   // wraps to 0 for cluster 65535
        return ENT_FREE;
    endfunction

    task automatic note_failure(input string what, input logic [CLUSTER_W-1:0] c,
                                input logic [ENTRY_W-1:0] want,
                                input logic [ENTRY_W-1:0] got);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%0t: %s cluster %0d expected %h actual %h", $realtime, what, c,
                     want, got);
    endtask

    task automatic queue_query(input logic [CLUSTER_W-1:0] c);
        disk_req_t req;
        req.kind    = KIND_QUERY;
        req.slot    = SLOT_W'($urandom);
        req.start   = CLUSTER_W'($urandom);
        req.len     = $urandom;
        req.cluster = c;
        disk_requests.push_back(req);
    endtask

    task automatic queue_load(input logic [SLOT_W-1:0] slot,
                              input logic [CLUSTER_W-1:0] start,
                              input logic [LEN_W-1:0] len);
        disk_req_t req;
        req.kind    = KIND_LOAD;
        req.slot    = slot;
        req.start   = start;
        req.len     = len;
        req.cluster = CLUSTER_W'($urandom);
        disk_requests.push_back(req);
    endtask

    // Hold the sequencer until every queued transaction is accepted and every
    // predicted entry has come back, then let a load still in flight retire.
    task automatic wait_idle();
        while (disk_requests.size() != 0 || in_valid || due_entries.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // Write one register; only called while the generator is idle, so the
    // shadow copy may be updated right at the handshake.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_MAX_CLUSTER:  max_cluster_r  = val;
            REG_FILE_COUNT:   file_count_r   = val[FCNT_W-1:0];
            REG_CLUSTER_LOG2: cluster_log2_r = val[CSL_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int unsigned mode);
        case (mode)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 72; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 72; end
            default: begin sender_idle_pct = 27; recv_stall_pct = 27; end
        endcase
    endtask

    // Lay out contiguous files in ascending order, then queue mostly chain
    // walks over them, with scattered lookups and stray table loads mixed in.
    task automatic plan_phase();
        int unsigned n;
        int unsigned base;
        int unsigned base_hi;
        int unsigned unit_shift;
        int unsigned queued;
        int unsigned r;
        int unsigned f;
        int unsigned c;
        int unsigned last_c;
        n = (file_count_r < TBL_DEPTH) ? file_count_r : TBL_DEPTH;
        unit_shift = BLOCK_SHIFT + cluster_log2_r;
        base_hi = (max_cluster_r > 400) ? max_cluster_r - 300 : 2;
        if (base_hi > 60000)
            base_hi = 60000;
        base = $urandom_range(base_hi, 2);
        lay_lo = base;
        queued = 0;
        for (int i = 0; i < n; i++)
        begin
            lay_start[i] = base;
            lay_span[i]  = $urandom_range(12, 0);
            queue_load(SLOT_W'(i), CLUSTER_W'(base), (lay_span[i] << unit_shift) |
                       $urandom_range((1 << unit_shift) - 1, 0));
            queued++;
            base += lay_span[i] + 1 + $urandom_range(3, 0);
        end
        lay_hi = base + 4;

        while (queued < PHASE_ITEMS)
        begin
            r = $urandom_range(99, 0);
            if (n != 0 && r < 60)
            begin
                // Walk one chain, mostly from its head, one past its end.
                f = $urandom_range(n - 1, 0);
                c = lay_start[f];
                if ($urandom_range(3, 0) == 0)
                    c += $urandom_range(lay_span[f], 0);
                last_c = lay_start[f] + lay_span[f] + 1;
                while (c <= last_c)
                begin
                    queue_query(CLUSTER_W'(c));
                    queued++;
                    c++;
                end
            end
            else if (r < 78)
            begin
                queue_query(CLUSTER_W'($urandom_range(lay_hi, (lay_lo > 3) ? lay_lo - 3 : 0)));
                queued++;
            end
            else if (r < 92)
            begin
                if ($urandom_range(3, 0) == 0)
                    queue_query(CLUSTER_W'($urandom_range(1, 0)));
                else
                    queue_query(CLUSTER_W'($urandom_range(65535, 0)));
                queued++;
            end
            else
            begin
                queue_load(SLOT_W'($urandom_range(TBL_DEPTH - 1, 0)),
                           CLUSTER_W'($urandom_range(65535, 0)), $urandom);
                queued++;
            end
        end
    endtask

    // Driver: change inputs on the falling edge only. Hold valid and payload
    // until the transaction is taken, then advance to the next pending item
    // or idle, using a single assignment per signal per edge.
    always @(negedge clk)
    begin
        disk_req_t req;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || req_taken)
        begin
            if (disk_requests.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct)
            begin
                req = disk_requests.pop_front();
                in_valid       <= 1'b1;
                kind           <= req.kind;
                entry_slot     <= req.slot;
                first_cluster  <= req.start;
                byte_length    <= req.len;
                cluster_number <= req.cluster;
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= rst_n && ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // Monitor: sample both channels on the rising edge. Check the result
    // side first so a stray entry never pairs with a query taken this edge.
    always @(posedge clk)
    begin
        fat_answer_t due;
        fat_answer_t fresh;
        req_taken <= rst_n && in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (due_entries.size() == 0)
                note_failure("unexpected entry,", 16'd0, 16'd0, fat_entry);
            else
            begin
                due = due_entries.pop_front();
                if (fat_entry !== due.entry)
                    note_failure("fat_entry mismatch,", due.cluster, due.entry, fat_entry);
            end
        end
        if (rst_n && in_valid && in_ready)
        begin
            if (kind == KIND_LOAD)
            begin
                tbl_start[entry_slot] = first_cluster;
                tbl_len[entry_slot]   = byte_length;
            end
            else
            begin
                fresh.cluster = cluster_number;
                fresh.entry   = fat_lookup(cluster_number);
                due_entries.push_back(fresh);
            end
        end
    end

    // Watchdog: fail the run once it reaches the cycle limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        logic [MAXC_W-1:0] ph_max;
        logic [FCNT_W-1:0] ph_count;
        logic [CSL_W-1:0]  ph_log2;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings, empty table: fixed codes, bad clusters and the
        // free answer of an empty table. No table slot is read here.
        set_idling(0);
        queue_query(16'd0);
        queue_query(16'd1);
        queue_query(16'(MAX_CLUSTER_RST));
        queue_query(16'd65535);
        queue_query(16'd2);
        wait_idle();

        // Widest cluster range, full table; poke the unmapped index too.
        write_reg(REG_MAX_CLUSTER, 17'd65536);
        write_reg(REG_FILE_COUNT, 17'd16);
        write_reg(REG_CLUSTER_LOG2, 17'd0);
        write_reg(REG_SPARE, 17'h1FFFF);

        // Fill every slot so no later walk touches an unwritten entry.
        queue_load(4'd0, 16'd5, 32'd0);
        for (int i = 1; i < 14; i++)
            queue_load(SLOT_W'(i), CLUSTER_W'(20 + (i - 1) * 40),
                       ((2 * i) << BLOCK_SHIFT) | 32'h1FF);
        queue_load(4'd14, 16'hFFFF, 32'd0);
        queue_load(4'd15, 16'd65530, 32'hFFFF_FFFF);

        queue_query(16'd2);      // before the first file: answered from entry 0
        queue_query(16'd5);      // zero-length file ends where it starts
        queue_query(16'd20);
        queue_query(16'd22);     // end of a two-cluster chain
        queue_query(16'd23);     // past the end: free
        queue_query(16'd3);      // behind the index: restart the walk
        queue_query(16'd65535);  // next cluster wraps to 0
        queue_query(16'd526);    // walk back from the last entry
        wait_idle();

        // Random phases: sweep register settings and idling patterns.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin ph_max = 17'd65525; ph_count = 5'd16; ph_log2 = 3'd0; end
                1: begin ph_max = 17'd65536; ph_count = 5'd8;  ph_log2 = 3'd7; end
                2: begin ph_max = 17'd40000; ph_count = 5'd3;  ph_log2 = 3'd3; end
                3: begin ph_max = 17'd2;     ph_count = 5'd5;  ph_log2 = 3'd1; end
                4: begin ph_max = 17'd0;     ph_count = 5'd16; ph_log2 = 3'd2; end
                5:
                begin
                    ph_max   = MAXC_W'($urandom_range(65536, 0));
                    ph_count = FCNT_W'($urandom_range(16, 0));
                    ph_log2  = CSL_W'($urandom_range(7, 0));
                end
                6: begin ph_max = 17'd1000;  ph_count = 5'd12; ph_log2 = 3'd4; end
                default: begin ph_max = 17'd65535; ph_count = 5'd0; ph_log2 = 3'd6; end
            endcase
            write_reg(REG_MAX_CLUSTER, ph_max);
            write_reg(REG_FILE_COUNT, 17'(ph_count));
            write_reg(REG_CLUSTER_LOG2, 17'(ph_log2));
            set_idling(ph % 4);
            plan_phase();
            wait_idle();
        end

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
